FILE: rtl/running_rank_min_cost_core_defines.svh
// Assertion macros shared by the RTL. Each expands to a labelled concurrent
// assertion on the rising edge of clk_i, switched off while rst_ni is low.
`ifndef RUNNING_RANK_MIN_COST_CORE_DEFINES_SVH
`define RUNNING_RANK_MIN_COST_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RRMC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rrmc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RRMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rrmc assertion failed");

`endif

FILE: rtl/rrmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rrmc_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 6;
  localparam int unsigned StepW  = 5;
  localparam int unsigned TotalW = 11;
  // Common width for saturation arithmetic; holds any count and any total sum.
  localparam int unsigned WideW  = 12;

  localparam logic [WideW-1:0] CntMax   = 12'd63;
  localparam logic [WideW-1:0] StepMax  = 12'd31;
  localparam logic [WideW-1:0] TotalMax = 12'd2047;

  // Control part of a query travelling down the chain.
  typedef struct packed {
    logic valid;  // a query occupies this stage
    logic first;  // query opens a new sequence
    logic full;   // store was full on entry: no compare, no write
  } tok_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/rrmc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module rrmc_cell #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned IDX      = 0
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 en_i,
  input  wire rrmc_pkg::tok_ctrl_t                  ctrl_i,
  input  wire logic signed [rrmc_pkg::ValueW-1:0]   key_i,
  input  wire logic [$clog2(CAPACITY+1)-1:0]        cnt_i,
  input  wire logic [$clog2(CAPACITY+1)-1:0]        less_i,
  input  wire logic [$clog2(CAPACITY+1)-1:0]        more_i,
  output rrmc_pkg::tok_ctrl_t                       ctrl_o,
  output logic signed [rrmc_pkg::ValueW-1:0]        key_o,
  output logic [$clog2(CAPACITY+1)-1:0]             cnt_o,
  output logic [$clog2(CAPACITY+1)-1:0]             less_o,
  output logic [$clog2(CAPACITY+1)-1:0]             more_o
);
  import rrmc_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY+1);
  localparam logic [CW-1:0] MyIdx = CW'(IDX);

  logic signed [ValueW-1:0] stored_q;
  tok_ctrl_t                ctrl_q;
  logic signed [ValueW-1:0] key_q;
  logic [CW-1:0]            cnt_q, less_q, more_q;
  logic                     live, occupied, wr;
  logic [CW-1:0]            less_d, more_d;

  // The entry is occupied for this query when its slot lies below the
  // query's own fill count; the query writes the first free slot.
  assign live     = ctrl_i.valid && !ctrl_i.full;
  assign occupied = live && (MyIdx < cnt_i);
  assign wr       = live && (MyIdx == cnt_i);

  always_comb begin
    less_d = less_i;
    more_d = more_i;
    if (occupied) begin
      if (stored_q < key_i) begin
        less_d = less_i + CW'(1);
      end else if (stored_q > key_i) begin
        more_d = more_i + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && wr) begin
      stored_q <= key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      key_q  <= key_i;
      cnt_q  <= cnt_i;
      less_q <= less_d;
      more_q <= more_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign key_o  = key_q;
  assign cnt_o  = cnt_q;
  assign less_o = less_q;
  assign more_o = more_q;

endmodule
`default_nettype wire

FILE: rtl/rrmc_tail.sv
`timescale 1ns / 1ps
`default_nettype none
module rrmc_tail #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                en_i,
  input  wire rrmc_pkg::tok_ctrl_t                 ctrl_i,
  input  wire logic [$clog2(CAPACITY+1)-1:0]       less_i,
  input  wire logic [$clog2(CAPACITY+1)-1:0]       more_i,
  output logic                                     valid_o,
  output logic [rrmc_pkg::CountW-1:0]              smaller_o,
  output logic [rrmc_pkg::CountW-1:0]              larger_o,
  output logic [rrmc_pkg::StepW-1:0]               step_o,
  output logic [rrmc_pkg::TotalW-1:0]              total_o,
  output logic                                     full_o
);
  import rrmc_pkg::*;

  logic [WideW-1:0]  less_w, more_w, step_w, base_w, sum_w;
  logic [TotalW-1:0] total_q, total_d;
  logic              valid_q, full_q;
  logic [CountW-1:0] smaller_q, larger_q, smaller_d, larger_d;
  logic [StepW-1:0]  step_q, step_d;

  always_comb begin
    less_w = WideW'(less_i);
    more_w = WideW'(more_i);
    step_w = (less_w < more_w) ? less_w : more_w;
    base_w = ctrl_i.first ? '0 : WideW'(total_q);
    sum_w  = base_w + step_w;
    if (ctrl_i.full) begin
      smaller_d = '0;
      larger_d  = '0;
      step_d    = '0;
      total_d   = base_w[TotalW-1:0];
    end else begin
      smaller_d = (less_w > CntMax) ? CntMax[CountW-1:0] : less_w[CountW-1:0];
      larger_d  = (more_w > CntMax) ? CntMax[CountW-1:0] : more_w[CountW-1:0];
      step_d    = (step_w > StepMax) ? StepMax[StepW-1:0] : step_w[StepW-1:0];
      total_d   = (sum_w > TotalMax) ? TotalMax[TotalW-1:0] : sum_w[TotalW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      total_q <= '0;
    end else if (en_i) begin
      valid_q <= ctrl_i.valid;
      if (ctrl_i.valid) begin
        total_q <= total_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && ctrl_i.valid) begin
      smaller_q <= smaller_d;
      larger_q  <= larger_d;
      step_q    <= step_d;
      full_q    <= ctrl_i.full;
    end
  end

  assign valid_o   = valid_q;
  assign smaller_o = smaller_q;
  assign larger_o  = larger_q;
  assign step_o    = step_q;
  assign total_o   = total_q;
  assign full_o    = full_q;

endmodule
`default_nettype wire

FILE: rtl/running_rank_min_cost_core.sv
// Running rank cost core.
// Input channel: value_i (signed 32 bit) and first_i travel as one beat under
// in_valid_i / in_stall_o; a beat is taken at a rising edge with valid high
// and stall low. A first mark empties the store and clears the total before
// the beat is handled.
// Output channel: one result beat per input beat under out_valid_o /
// out_stall_i, carrying both counts, the step cost, the running total and
// the store-full flag, in input order.
// The store is a chain of CAPACITY cells, one stored value each. A query
// walks one cell per cycle unless the chain stalls, comparing against occupied
// cells and writing itself into the first free one; the tail then registers
// the result. A new query can follow at one beat per cycle while unstalled.
// When the receiver stalls with a result waiting, the whole chain and the
// output register hold, and in_stall_o rises in the same cycle.
// Reset empties the store, clears the total and drops every query in flight;
// stored values themselves are not cleared, as only slots below the fill
// count are ever compared.
`timescale 1ns / 1ps
`default_nettype none
`include "running_rank_min_cost_core_defines.svh"
module running_rank_min_cost_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [rrmc_pkg::ValueW-1:0]  value_i,
  input  wire logic                                first_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [rrmc_pkg::CountW-1:0]              smaller_count_o,
  output logic [rrmc_pkg::CountW-1:0]              larger_count_o,
  output logic [rrmc_pkg::StepW-1:0]               step_cost_o,
  output logic [rrmc_pkg::TotalW-1:0]              total_cost_o,
  output logic                                     store_full_o
);
  import rrmc_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY+1);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  logic          en;
  logic [CW-1:0] cnt_q, cnt_d, cur_cnt;
  logic          accept;

  // Per-stage links of the chain; link 0 is the entry, link CAPACITY the tail.
  tok_ctrl_t                ln_ctrl [CAPACITY+1];
  logic signed [ValueW-1:0] ln_key  [CAPACITY+1];
  logic [CW-1:0]            ln_cnt  [CAPACITY+1];
  logic [CW-1:0]            ln_less [CAPACITY+1];
  logic [CW-1:0]            ln_more [CAPACITY+1];

  // The chain moves only when the output register is empty or being taken.
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;

  // The fill count is tracked at the entry; each query carries the count it
  // saw, so later queries see every earlier write by the time they arrive.
  always_comb begin
    cur_cnt = first_i ? '0 : cnt_q;
    cnt_d   = (cur_cnt == CapCount) ? cur_cnt : cur_cnt + CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  assign ln_ctrl[0] = '{valid: in_valid_i, first: first_i, full: (cur_cnt == CapCount)};
  assign ln_key[0]  = value_i;
  assign ln_cnt[0]  = cur_cnt;
  assign ln_less[0] = '0;
  assign ln_more[0] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    rrmc_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctrl_i (ln_ctrl[g]),
      .key_i  (ln_key[g]),
      .cnt_i  (ln_cnt[g]),
      .less_i (ln_less[g]),
      .more_i (ln_more[g]),
      .ctrl_o (ln_ctrl[g+1]),
      .key_o  (ln_key[g+1]),
      .cnt_o  (ln_cnt[g+1]),
      .less_o (ln_less[g+1]),
      .more_o (ln_more[g+1])
    );
  end

  rrmc_tail #(
    .CAPACITY (CAPACITY)
  ) u_tail (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .ctrl_i    (ln_ctrl[CAPACITY]),
    .less_i    (ln_less[CAPACITY]),
    .more_i    (ln_more[CAPACITY]),
    .valid_o   (out_valid_o),
    .smaller_o (smaller_count_o),
    .larger_o  (larger_count_o),
    .step_o    (step_cost_o),
    .total_o   (total_cost_o),
    .full_o    (store_full_o)
  );

  // A flagged result carries no counts.
  `RRMC_ASSERT_NOW(a_full_no_counts, out_valid_o && store_full_o,
    smaller_count_o == '0 && larger_count_o == '0 && step_cost_o == '0)
  // The step cost never exceeds either reported count.
  `RRMC_ASSERT_NOW(a_step_bounded, out_valid_o,
    {1'b0, step_cost_o} <= smaller_count_o && {1'b0, step_cost_o} <= larger_count_o)
  // The fill count never passes the capacity.
  `RRMC_ASSERT_NOW(a_cnt_bounded, 1'b1, cnt_q <= CapCount)
  // A first-marked beat leaves exactly one stored value behind.
  `RRMC_ASSERT_NEXT(a_first_restarts, accept && first_i, cnt_q == CW'(1))

endmodule
`default_nettype wire
